### rtl/core/mcsv_pkg.sv
// Shared types and constants for the container size validator.
package mcsv_pkg;

	localparam int POS_W = 29;
	localparam int CNT_W = 17;
	localparam int DEF_WINDOW_BYTES = 268435456;
	localparam int DEF_MAX_RECORDS = 100000;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_MAGIC  = 3'd1;
	localparam logic [2:0] ST_TABLE  = 3'd2;
	localparam logic [2:0] ST_ORDER  = 3'd3;
	localparam logic [2:0] ST_SIG    = 3'd4;
	localparam logic [2:0] ST_OUTSIDE = 3'd5;
	localparam logic [2:0] ST_BIG    = 3'd6;

	localparam logic [31:0] TAG_BOOK = 32'h424F4F4B;
	localparam logic [31:0] TAG_MOBI = 32'h4D4F4249;
	localparam logic [31:0] TAG_FLIS = 32'h464C4953;
	localparam logic [31:0] TAG_FCIS = 32'h46434953;
	localparam logic [31:0] TAG_FDST = 32'h46445354;
	localparam logic [31:0] TAG_INDX = 32'h494E4458;
	localparam logic [31:0] TAG_SRCS = 32'h53524353;
	localparam logic [31:0] TAG_EOF  = 32'hE98E0D0A;
	localparam logic [31:0] TAG_PNG  = 32'h89504E47;
	localparam logic [31:0] TAG_IEND = 32'h49454E44;
	localparam logic [15:0] JPG_SOI  = 16'hFFD8;
	localparam logic [15:0] JPG_EOI  = 16'hFFD9;
	localparam logic [15:0] JPG_SOS  = 16'hFFDA;
	localparam logic [31:0] LEN_MAX  = 32'd1048576;

	typedef enum logic [3:0] {
		PH_HEADER, PH_TABLE, PH_TAG, PH_LEN, PH_PNG, PH_PNG_FOUND,
		PH_JMARK, PH_JLEN, PH_JSCAN, PH_DONE, PH_DEAD
	} phase_t;

	typedef enum logic [1:0] {
		S_RUN, S_EVAL, S_DIV, S_OUT
	} ctl_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h54;
			3'd1: r = 8'h45;
			3'd2: r = 8'h58;
			3'd3: r = 8'h74;
			3'd4: r = 8'h52;
			3'd5: r = 8'h45;
			3'd6: r = 8'h41;
			3'd7: r = 8'h64;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/mcsv_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mcsv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [16:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import mcsv_pkg::*;

	logic [17:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] shifted;
	logic        fits;

	assign shifted = {rem_q[16:0], quo_q[31]};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

### rtl/core/mobi_container_size_validator_core.sv
// Top level: streaming container header check and last-record sizing.
// Bytes are taken one per cycle while a window streams in.
// After the final beat the result is registered from an evaluate state, or from a
// divide state when the average record span is needed (serial divider).
// The next window starts once the result beat has been taken.
// arst_n clears all parse and control state asynchronously.
module mobi_container_size_validator_core #(
	parameter int WINDOW_BYTES = mcsv_pkg::DEF_WINDOW_BYTES,
	parameter int MAX_RECORDS  = mcsv_pkg::DEF_MAX_RECORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] status, [31:3] container size
	output logic        m_tuser    // [0] valid_res
);
	import mcsv_pkg::*;

	ctl_t ctl_q, ctl_n;
	phase_t ph_q, ph_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [31:0] win_q, win_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, idx_q, idx_n;
	logic [31:0] prev_q, prev_n, first_q, first_n, last_q, last_n, tag_q, tag_n;
	logic [32:0] nmp_q, nmp_n;
	logic [POS_W-1:0] llen_q, llen_n;
	logic [2:0] fail_q, fail_n;
	logic out_valid_q;
	logic [2:0] out_code_q;
	logic [POS_W-1:0] out_total_q;

	logic take, fin_take, out_take;
	logic div_start, div_done;
	logic [31:0] div_q;

	assign take = s_tvalid && s_tready;
	assign fin_take = take && s_tlast;
	assign out_take = m_tvalid && m_tready;

	always_comb begin
		logic [33:0] p, f, l, nm;
		logic [31:0] w;
		logic [15:0] m;
		logic [31:0] dflt;
		ph_n = ph_q; pos_n = pos_q; win_n = win_q; cnt_n = cnt_q; idx_n = idx_q;
		prev_n = prev_q; first_n = first_q; last_n = last_q; tag_n = tag_q;
		nmp_n = nmp_q; llen_n = llen_q; fail_n = fail_q;
		p = {5'd0, pos_q};
		f = {2'd0, first_q};
		l = {2'd0, last_q};
		w = {win_q[23:0], s_tdata};
		m = w[15:0];
		nm = '0;
		dflt = '0;
		if (take && (pos_q < POS_W'(WINDOW_BYTES))) begin
			win_n = w;
			pos_n = pos_q + 1'b1;
			case (ph_q)
				PH_HEADER: begin
					if (p == 34'd63 && w != TAG_BOOK) begin
						fail_n = ST_MAGIC; ph_n = PH_DEAD;
					end else if (p == 34'd67 && w != TAG_MOBI) begin
						fail_n = ST_MAGIC; ph_n = PH_DEAD;
					end else if (p == 34'd77) begin
						if (m == 16'd0 || {1'b0, m} > CNT_W'(MAX_RECORDS)) begin
							fail_n = ST_TABLE; ph_n = PH_DEAD;
						end else begin
							cnt_n = {1'b0, m};
							prev_n = 32'd78 + {13'd0, m, 3'd0};
							idx_n = '0;
							ph_n = PH_TABLE;
						end
					end
				end
				PH_TABLE: begin
					if (p == 34'd81 + {14'd0, idx_q, 3'd0}) begin
						if (w < prev_q) begin
							fail_n = ST_ORDER; ph_n = PH_DEAD;
						end else begin
							prev_n = w;
							if (idx_q == '0) first_n = w;
							if (idx_q + 1'b1 == cnt_q) begin
								last_n = w; ph_n = PH_TAG;
							end
							idx_n = idx_q + 1'b1;
						end
					end
				end
				PH_DEAD: ;
				default: begin
					if (p >= f && p < f + 34'd8 &&
					    s_tdata != sig_byte(3'(p - f))) begin
						fail_n = ST_SIG; ph_n = PH_DEAD;
					end else begin
						if (ph_n == PH_TAG && p == l + 34'd3) begin
							tag_n = w;
							case (w)
								TAG_FLIS: dflt = 32'd36;
								TAG_FCIS: dflt = 32'd44;
								TAG_FDST: dflt = 32'd12;
								TAG_INDX: dflt = 32'd192;
								TAG_SRCS: dflt = 32'd16;
								default: dflt = 32'd0;
							endcase
							if (dflt != 32'd0) begin
								llen_n = POS_W'(dflt); ph_n = PH_LEN;
							end else if (w == TAG_EOF) begin
								llen_n = POS_W'(4); ph_n = PH_DONE;
							end else if (w == TAG_PNG) begin
								nmp_n = {1'b0, last_q} + 33'd8; ph_n = PH_PNG;
							end else if (w[31:16] == JPG_SOI) begin
								nmp_n = {1'b0, last_q} + 33'd2; ph_n = PH_JMARK;
							end else begin
								ph_n = PH_DONE;
							end
						end
						if (ph_n == PH_LEN && p == l + 34'd7) begin
							if (w != 32'd0 && w <= LEN_MAX) llen_n = POS_W'(w + 32'd8);
							ph_n = PH_DONE;
						end
						nm = {1'b0, nmp_n};
						if (ph_n == PH_PNG) begin
							if (p == nm + 34'd3) begin
								tag_n = w;
							end else if (p == nm + 34'd7) begin
								if (w == TAG_IEND) begin
									llen_n = POS_W'(nm + 34'd12 - l);
									ph_n = PH_PNG_FOUND;
								end else if (tag_q[31]) begin
									ph_n = PH_DONE;
								end else begin
									nmp_n = 33'(nm + 34'd12 + {2'd0, tag_q});
								end
							end
						end
						nm = {1'b0, nmp_n};
						if (ph_n == PH_JMARK && p == nm + 34'd1) begin
							if (m == JPG_EOI) begin
								llen_n = POS_W'(p + 34'd1 - l); ph_n = PH_DONE;
							end else if (m == JPG_SOI) begin
								nmp_n = 33'(nm + 34'd2);
							end else if (m[15:8] != 8'hFF) begin
								ph_n = PH_DONE;
							end else begin
								tag_n = {16'd0, m}; ph_n = PH_JLEN;
							end
						end
						nm = {1'b0, nmp_n};
						if (ph_n == PH_JLEN && p == nm + 34'd3) begin
							if (m < 16'd2) begin
								ph_n = PH_DONE;
							end else begin
								nmp_n = 33'(nm + 34'd2 + {18'd0, m});
								ph_n = (tag_n[15:0] == JPG_SOS) ? PH_JSCAN : PH_JMARK;
							end
						end
						nm = {1'b0, nmp_n};
						if (ph_n == PH_JSCAN && p >= nm + 34'd1 && m == JPG_EOI) begin
							llen_n = POS_W'(p + 34'd1 - l); ph_n = PH_DONE;
						end
					end
				end
			endcase
		end
	end

	// final evaluation from registered parse state
	logic [33:0] wl, lo, fo;
	logic [2:0] ev_code;
	logic [POS_W-1:0] ev_len, sel_len, avg_len;
	logic need_div;
	logic [33:0] total;

	assign wl = {5'd0, pos_q};
	assign lo = {2'd0, last_q};
	assign fo = {2'd0, first_q};

	always_comb begin
		ev_code = ST_OK;
		ev_len = llen_q;
		need_div = 1'b0;
		if (wl < 34'd68 || fail_q == ST_MAGIC) ev_code = ST_MAGIC;
		else if (wl < 34'd78 || fail_q == ST_TABLE ||
		         34'd78 + {14'd0, cnt_q, 3'd0} > wl) ev_code = ST_TABLE;
		else if (fail_q == ST_ORDER) ev_code = ST_ORDER;
		else if (fail_q == ST_SIG || fo + 34'd8 > wl) ev_code = ST_SIG;
		else if (lo >= wl) ev_code = ST_OUTSIDE;
		if (ph_q == PH_PNG_FOUND && lo + {5'd0, llen_q} > wl) ev_len = '0;
		if (ev_len == '0) begin
			if (cnt_q > CNT_W'(1)) need_div = 1'b1;
			else ev_len = POS_W'(240);
		end
	end

	always_comb begin
		if (div_q < 32'd16) avg_len = POS_W'(16);
		else if (div_q > 32'd65536) avg_len = POS_W'(65536);
		else avg_len = POS_W'(div_q);
	end

	assign sel_len = (ctl_q == S_DIV) ? avg_len : ev_len;
	assign total = lo + {5'd0, sel_len};
	assign div_start = (ctl_q == S_EVAL) && (ev_code == ST_OK) && need_div;

	mcsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (last_q - first_q),
		.divisor  (cnt_q - 1'b1),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		ctl_n = ctl_q;
		case (ctl_q)
			S_RUN:  if (fin_take) ctl_n = S_EVAL;
			S_EVAL: ctl_n = div_start ? S_DIV : S_OUT;
			S_DIV:  if (div_done) ctl_n = S_OUT;
			S_OUT:  if (out_take) ctl_n = S_RUN;
			default: ctl_n = S_RUN;
		endcase
	end

	always_comb begin
		s_tready = (ctl_q == S_RUN);
		m_tvalid = (ctl_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= S_RUN;
			ph_q <= PH_HEADER;
			pos_q <= '0; win_q <= '0; cnt_q <= '0; idx_q <= '0;
			prev_q <= '0; first_q <= '0; last_q <= '0; tag_q <= '0;
			nmp_q <= '0; llen_q <= '0; fail_q <= '0;
		end else begin
			ctl_q <= ctl_n;
			if (out_take) begin
				ph_q <= PH_HEADER;
				pos_q <= '0; win_q <= '0; cnt_q <= '0; idx_q <= '0;
				prev_q <= '0; first_q <= '0; last_q <= '0; tag_q <= '0;
				nmp_q <= '0; llen_q <= '0; fail_q <= '0;
			end else begin
				ph_q <= ph_n;
				pos_q <= pos_n; win_q <= win_n; cnt_q <= cnt_n; idx_q <= idx_n;
				prev_q <= prev_n; first_q <= first_n; last_q <= last_n; tag_q <= tag_n;
				nmp_q <= nmp_n; llen_q <= llen_n; fail_q <= fail_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl_q == S_EVAL && !div_start) || (ctl_q == S_DIV && div_done)) begin
			if (ctl_q == S_EVAL && ev_code != ST_OK) begin
				out_code_q <= ev_code;
				out_valid_q <= 1'b0;
				out_total_q <= '0;
			end else if (total > wl) begin
				out_code_q <= ST_BIG;
				out_valid_q <= 1'b0;
				out_total_q <= '0;
			end else begin
				out_code_q <= ST_OK;
				out_valid_q <= 1'b1;
				out_total_q <= POS_W'(total);
			end
		end
	end

	assign m_tdata = {out_total_q, out_code_q};
	assign m_tuser = out_valid_q;
endmodule

### rtl/core/mcsv_checker.sv
// Port-level checker for the container size validator, bound to the top level.
module mcsv_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open while result pending");
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input stalled inside a window");
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0)
		else $error("valid result with nonzero status");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:3] == 29'd0 && m_tdata[2:0] != 3'd0)
		else $error("invalid result with size or ok status");
endmodule

bind mobi_container_size_validator_core mcsv_port_checks u_mcsv_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### sim/mcsv_checker.sv
// Checker: watches both streams, predicts each window result and compares.
`timescale 1ns / 1ps
module mcsv_checker #(
	parameter int WINDOW_BYTES = 256,
	parameter int MAX_RECORDS  = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          outstanding
);
	import mcsv_pkg::*;

	typedef struct {
		logic        ok;
		logic [2:0]  status;
		logic [28:0] size;
	} verdict_t;

	verdict_t verdict_q[$];

	logic [63:0] pos, shreg, rec_cnt, rec_idx, prev_off, first_off, tail_off;
	logic [63:0] tag, mark_pos, rec_len;
	logic [2:0]  fcode;
	phase_t      phase;

	initial errors = 0;
	assign outstanding = verdict_q.size();

	task automatic clear_parse();
		pos = 0; shreg = 0; phase = PH_HEADER; rec_cnt = 0; rec_idx = 0;
		prev_off = 0; first_off = 0; tail_off = 0; tag = 0; mark_pos = 0;
		rec_len = 0; fcode = ST_OK;
	endtask

	initial clear_parse();

	task automatic die(input logic [2:0] c);
		fcode = c;
		phase = PH_DEAD;
	endtask

	task automatic sort_tag(input logic [63:0] t);
		logic [63:0] dflt;
		dflt = 0;
		tag = t;
		if (t == TAG_FLIS) dflt = 36;
		else if (t == TAG_FCIS) dflt = 44;
		else if (t == TAG_FDST) dflt = 12;
		else if (t == TAG_INDX) dflt = 192;
		else if (t == TAG_SRCS) dflt = 16;
		if (dflt != 0) begin
			rec_len = dflt;
			phase = PH_LEN;
		end else if (t == TAG_EOF) begin
			rec_len = 4;
			phase = PH_DONE;
		end else if (t == TAG_PNG) begin
			mark_pos = tail_off + 8;
			phase = PH_PNG;
		end else if (t[31:16] == JPG_SOI) begin
			mark_pos = tail_off + 2;
			phase = PH_JMARK;
		end else begin
			phase = PH_DONE;
		end
	endtask

	task automatic take_byte(input logic [63:0] p, input logic [7:0] b);
		logic [63:0] w, m;
		shreg = {32'd0, shreg[23:0], b};
		w = shreg;
		if (phase == PH_HEADER) begin
			if (p == 63 && w != TAG_BOOK) die(ST_MAGIC);
			else if (p == 67 && w != TAG_MOBI) die(ST_MAGIC);
			else if (p == 77) begin
				m = w & 64'hFFFF;
				if (m < 1 || m > MAX_RECORDS) die(ST_TABLE);
				else begin
					rec_cnt = m;
					prev_off = 78 + 8 * m;
					rec_idx = 0;
					phase = PH_TABLE;
				end
			end
			return;
		end
		if (phase == PH_TABLE) begin
			if (p == 81 + 8 * rec_idx) begin
				if (w < prev_off) begin
					die(ST_ORDER);
					return;
				end
				prev_off = w;
				if (rec_idx == 0) first_off = w;
				if (rec_idx + 1 == rec_cnt) begin
					tail_off = w;
					phase = PH_TAG;
				end
				rec_idx++;
			end
			return;
		end
		if (phase == PH_DEAD) return;
		if (p >= first_off && p < first_off + 8) begin
			if (b != sig_byte(3'(p - first_off))) begin
				die(ST_SIG);
				return;
			end
		end
		if (phase == PH_TAG && p == tail_off + 3) sort_tag(w);
		if (phase == PH_LEN && p == tail_off + 7) begin
			if (w > 0 && w <= LEN_MAX) rec_len = 8 + w;
			phase = PH_DONE;
		end
		if (phase == PH_PNG) begin
			if (p == mark_pos + 3) tag = w;
			else if (p == mark_pos + 7) begin
				if (w == TAG_IEND) begin
					rec_len = mark_pos + 12 - tail_off;
					phase = PH_PNG_FOUND;
				end else if (tag > 64'h7FFFFFFF) begin
					phase = PH_DONE;
				end else begin
					mark_pos = mark_pos + 12 + tag;
				end
			end
		end
		if (phase == PH_JMARK && p == mark_pos + 1) begin
			m = w & 64'hFFFF;
			if (m == JPG_EOI) begin
				rec_len = p + 1 - tail_off;
				phase = PH_DONE;
			end else if (m == JPG_SOI) begin
				mark_pos += 2;
			end else if (m[15:8] != 8'hFF) begin
				phase = PH_DONE;
			end else begin
				tag = m;
				phase = PH_JLEN;
			end
		end
		if (phase == PH_JLEN && p == mark_pos + 3) begin
			m = w & 64'hFFFF;
			if (m < 2) phase = PH_DONE;
			else begin
				mark_pos = mark_pos + 2 + m;
				phase = (tag == JPG_SOS) ? PH_JSCAN : PH_JMARK;
			end
		end
		if (phase == PH_JSCAN && p >= mark_pos + 1 && w[15:0] == JPG_EOI) begin
			rec_len = p + 1 - tail_off;
			phase = PH_DONE;
		end
	endtask

	task automatic close_window();
		verdict_t v;
		logic [63:0] wl, len, total;
		logic [2:0]  c;
		wl = pos;
		total = 0;
		c = ST_OK;
		if (wl < 68 || fcode == ST_MAGIC) c = ST_MAGIC;
		else if (wl < 78 || fcode == ST_TABLE || 78 + 8 * rec_cnt > wl) c = ST_TABLE;
		else if (fcode == ST_ORDER) c = ST_ORDER;
		else if (fcode == ST_SIG || first_off + 8 > wl) c = ST_SIG;
		else if (tail_off >= wl) c = ST_OUTSIDE;
		else begin
			len = rec_len;
			if (phase == PH_PNG_FOUND && tail_off + len > wl) len = 0;
			if (len == 0) begin
				if (rec_cnt > 1) begin
					len = (tail_off - first_off) / (rec_cnt - 1);
					if (len < 16) len = 16;
					if (len > 65536) len = 65536;
				end else len = 240;
			end
			total = tail_off + len;
			if (total > wl) c = ST_BIG;
		end
		v.ok = (c == ST_OK);
		v.status = c;
		v.size = (c == ST_OK) ? total[28:0] : 29'd0;
		verdict_q = {verdict_q, v};
		clear_parse();
	endtask

	task automatic report(input string msg);
		$display("mcsv_checker: %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (pos < WINDOW_BYTES) begin
					take_byte(pos, s_tdata);
					pos++;
				end
				if (s_tlast) close_window();
			end
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) report("result beat with nothing pending");
				else begin
					e = verdict_q.pop_front();
					if (m_tuser !== e.ok)
						report($sformatf("valid got %b exp %b", m_tuser, e.ok));
					if (m_tdata[2:0] !== e.status)
						report($sformatf("status got %0d exp %0d", m_tdata[2:0], e.status));
					if (m_tdata[31:3] !== e.size)
						report($sformatf("size got %0d exp %0d", m_tdata[31:3], e.size));
				end
			end
		end
	end
endmodule

### sim/tb_top.sv
// Testbench top: drives byte windows into the validator and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
	import mcsv_pkg::*;

	localparam int WIN = 256;
	localparam int MAXR = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	int          errors, outstanding;
	logic        quiet = 1'b0;
	int          stall = 0;
	int          n_bytes = 0;
	logic [7:0]  win_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mobi_container_size_validator_core #(.WINDOW_BYTES(WIN), .MAX_RECORDS(MAXR)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	mcsv_checker #(.WINDOW_BYTES(WIN), .MAX_RECORDS(MAXR)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding)
	);

	// result side back-pressure
	always @(posedge clk) begin
		if (stall > 0) begin
			m_tready <= 1'b0;
			stall <= stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 4) == 0) stall <= $urandom_range(1, 3);
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		n_bytes++;
	endtask

	task automatic send_window();
		for (int i = 0; i < win_q.size(); i++)
			send_byte(win_q[i], i == win_q.size() - 1);
	endtask

	task automatic put32(input int at, input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			if (at + k < win_q.size()) win_q[at + k] = v[31 - 8 * k -: 8];
	endtask

	// kind: 0 length-tagged, 1 EOF, 2 PNG walk, 3 JPEG walk, 4 unknown tag
	task automatic build_window(input int kind);
		int n, fo, lo, p, total, seg;
		logic [31:0] tags[5];
		tags = '{TAG_FLIS, TAG_FCIS, TAG_FDST, TAG_INDX, TAG_SRCS};
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
		win_q.delete();
		repeat (WIN + 40) win_q = {win_q, 8'($urandom)};
		put32(60, TAG_BOOK);
		put32(64, TAG_MOBI);
		win_q[76] = 8'(n >> 8);
		win_q[77] = 8'(n);
		if (n > 4) n = 4;
		fo = 78 + 8 * n + $urandom_range(0, 4);
		p = fo;
		for (int r = 0; r < n; r++) begin
			put32(78 + 8 * r, p);
			lo = p;
			p = p + $urandom_range(8, 30);
		end
		for (int k = 0; k < 8; k++) win_q[fo + k] = sig_byte(3'(k));
		p = lo;
		case (kind)
			0: begin
				put32(p, tags[$urandom_range(0, 4)]);
				case ($urandom_range(0, 3))
					0: put32(p + 4, 0);
					1: put32(p + 4, $urandom);
					2: put32(p + 4, LEN_MAX);
					default: put32(p + 4, $urandom_range(1, 30));
				endcase
				p += 8 + $urandom_range(0, 30);
			end
			1: begin
				put32(p, TAG_EOF);
				p += 4;
			end
			2: begin
				put32(p, TAG_PNG);
				put32(p + 4, 32'h0D0A1A0A);
				p += 8;
				repeat ($urandom_range(0, 2)) begin
					seg = $urandom_range(0, 10);
					put32(p, seg);
					p += 12 + seg;
				end
				put32(p, 0);
				put32(p + 4, TAG_IEND);
				p += 12;
			end
			3: begin
				put32(p, {JPG_SOI, 16'hFFE0});
				p += 2;
				repeat ($urandom_range(0, 2)) begin
					seg = $urandom_range(2, 8);
					put32(p, {16'hFFE0, 16'(seg)});
					p += 2 + seg;
				end
				if ($urandom_range(0, 1)) begin
					put32(p, {JPG_SOS, 16'd4});
					p += 6 + $urandom_range(0, 12);
				end
				put32(p, {JPG_EOI, 16'h0000});
				p += 2;
			end
			default: begin
				put32(p, $urandom);
				p += 4 + $urandom_range(0, 30);
			end
		endcase
		total = p + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6));
		while (win_q.size() > total) void'(win_q.pop_back());
	endtask

	task automatic noise_window(input int len);
		win_q.delete();
		repeat (len) win_q = {win_q, 8'($urandom)};
	endtask

	initial begin
		int nwin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-byte windows, short header, one of each record kind
		win_q = '{8'h00};
		send_window();
		win_q = '{8'hFF};
		send_window();
		for (int k = 0; k < 5; k++) begin
			build_window(k);
			send_window();
		end
		build_window(0);
		while (win_q.size() > 70) void'(win_q.pop_back());
		send_window();

		nwin = 0;
		while (n_bytes < 1650 || nwin < 40) begin
			if (n_bytes > 1400) quiet = 1'b1;
			case ($urandom_range(0, 9))
				0: noise_window($urandom_range(1, 90));
				1: begin
					build_window($urandom_range(0, 4));
					win_q[$urandom_range(0, win_q.size() - 1)] = 8'($urandom);
				end
				2: begin
					build_window($urandom_range(0, 4));
					while (win_q.size() > 1 && $urandom_range(0, 7) != 0)
						void'(win_q.pop_back());
				end
				default: build_window($urandom_range(0, 4));
			endcase
			send_window();
			nwin++;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

### filelist.f
rtl/core/mcsv_pkg.sv
rtl/core/mcsv_div.sv
rtl/core/mobi_container_size_validator_core.sv
rtl/core/mcsv_checker.sv
sim/mcsv_checker.sv
sim/tb_top.sv
